FILE: hdl/itp_pkg.sv
// shared constants, types and helpers for the infix to postfix converter
// no dependencies; imported by itp_stack_ram and infix_to_postfix_converter
package itp_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);

   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
   localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHAR,
      ST_PUSH,
      ST_CLOSE,
      ST_OPPOP,
      ST_FLUSH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

   function automatic logic [1:0] prec_of(input logic [7:0] c);
      logic [1:0] p;
      case (c)
         CHAR_PLUS, CHAR_MINUS: p = 2'd1;
         CHAR_STAR, CHAR_SLASH: p = 2'd2;
         default:               p = 2'd0;
      endcase
      return p;
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

endpackage

FILE: hdl/itp_stack_ram.sv
// operator stack storage: one write port, one registered read port
// uses itp_pkg; same-address write forwards to the read data
module itp_stack_ram import itp_pkg::*; (
   input  logic              clock,
   input  ram_wr_type        wr,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [STACK_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (wr.en && (wr.addr == rd_addr)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/infix_to_postfix_converter.sv
// top level of the shunting-yard infix to postfix converter
// uses itp_pkg and itp_stack_ram
//
// One expression byte is taken per beat, one at a time; each beat yields a run of result
// beats, one per cycle while the output is not stalled. An operand byte is emitted, '(' is
// pushed, ')' pops entries down to its '(' and an operator pops entries of equal or higher
// precedence and is then pushed; a final byte then flushes every stack entry, and the run
// closes with a done beat. Pops go one per cycle, while the output is not stalled, through
// the stack memory's single read port, and one beat is held back so the last beat is known.
module infix_to_postfix_converter import itp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_end_of_expr,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_has_char,
   output logic [7:0] rsp_out_char,
   output logic [1:0] rsp_error_code,
   output logic       rsp_run_last
);

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] paren_ff, paren_in;
   logic             pend_valid_ff, pend_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       pend_char_ff, pend_char_in;
   logic [7:0]       char_ff, char_in;
   logic             last_ff, last_in;
   logic [1:0]       err_ff, err_in;
   logic             rsp_has_ff, rsp_has_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic [1:0]       rsp_err_ff, rsp_err_in;
   logic             rsp_last_ff, rsp_last_in;

   ram_wr_type       wr;
   logic [CNT_W-1:0] rd_cnt;
   logic [7:0]       top;
   logic             have_top, advance, accept;
   logic             pop_close, pop_op;
   logic             emit, rsp_load;
   logic [7:0]       emit_char;

   // read address follows the next count so top is always the current top entry
   assign rd_cnt = count_in - CNT_ONE;

   itp_stack_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_cnt[ADDR_W-1:0]),
      .rd_data (top)
   );

   assign have_top  = (count_ff != '0);
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign pop_close = have_top && (top != CHAR_OPEN);
   assign pop_op    = have_top && (prec_of(char_ff) <= prec_of(top));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_alnum(req_in_char)) begin
                  state_in = ST_CHAR;
               end else if (req_in_char == CHAR_OPEN) begin
                  state_in = ST_PUSH;
               end else if (req_in_char == CHAR_CLOSE) begin
                  state_in = ST_CLOSE;
               end else begin
                  state_in = ST_OPPOP;
               end
            end
         end
         ST_CHAR, ST_PUSH: begin
            if (advance) begin
               state_in = last_ff ? ST_FLUSH : ST_DONE;
            end
         end
         ST_CLOSE: begin
            if (advance && !pop_close) begin
               state_in = last_ff ? ST_FLUSH : ST_DONE;
            end
         end
         ST_OPPOP: begin
            if (advance && !pop_op) begin
               state_in = ST_PUSH;
            end
         end
         ST_FLUSH: begin
            if (advance && !have_top) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (advance) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in      = count_ff;
      paren_in      = paren_ff;
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      char_in       = char_ff;
      last_in       = last_ff;
      err_in        = err_ff;
      wr.en         = 1'b0;
      wr.addr       = count_ff[ADDR_W-1:0];
      wr.data       = char_ff;
      emit          = 1'b0;
      emit_char     = top;
      rsp_load      = 1'b0;
      rsp_has_in    = 1'b0;
      rsp_char_in   = 8'h00;
      rsp_err_in    = err_ff;
      rsp_last_in   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               char_in = req_in_char;
               last_in = req_end_of_expr;
               err_in  = ERR_NONE;
               // the error is settled up front since it rides on every beat of the run
               if (is_alnum(req_in_char)) begin
                  err_in = ERR_NONE;
               end else if (req_in_char == CHAR_OPEN) begin
                  if (count_ff == CNT_FULL) err_in = ERR_OVERFLOW;
               end else if (req_in_char == CHAR_CLOSE) begin
                  if (paren_ff == '0) err_in = ERR_UNDERFLOW;
               end else begin
                  if ((count_ff == CNT_FULL) && (prec_of(req_in_char) > prec_of(top)))
                     err_in = ERR_OVERFLOW;
               end
            end
         end
         ST_CHAR: begin
            if (advance) begin
               emit      = 1'b1;
               emit_char = char_ff;
            end
         end
         ST_PUSH: begin
            if (advance && (count_ff != CNT_FULL)) begin
               wr.en    = 1'b1;
               count_in = count_ff + CNT_ONE;
               if (char_ff == CHAR_OPEN) paren_in = paren_ff + CNT_ONE;
            end
         end
         ST_CLOSE: begin
            if (advance) begin
               if (pop_close) begin
                  emit     = 1'b1;
                  count_in = count_ff - CNT_ONE;
               end else if (have_top) begin
                  // matching open paren is dropped silently
                  count_in = count_ff - CNT_ONE;
                  paren_in = paren_ff - CNT_ONE;
               end
            end
         end
         ST_OPPOP, ST_FLUSH: begin
            if (advance && ((state_ff == ST_OPPOP) ? pop_op : have_top)) begin
               emit     = 1'b1;
               count_in = count_ff - CNT_ONE;
               if (top == CHAR_OPEN) paren_in = paren_ff - CNT_ONE;
            end
         end
         ST_DONE: begin
            if (advance) begin
               rsp_load      = 1'b1;
               rsp_has_in    = pend_valid_ff;
               rsp_char_in   = pend_valid_ff ? pend_char_ff : 8'h00;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: ;
      endcase

      // one beat is held back so the closing beat of the run can be flagged
      if (emit) begin
         pend_char_in  = emit_char;
         pend_valid_in = 1'b1;
         if (pend_valid_ff) begin
            rsp_load    = 1'b1;
            rsp_has_in  = 1'b1;
            rsp_char_in = pend_char_ff;
            rsp_last_in = 1'b0;
         end
      end

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         paren_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         paren_ff      <= paren_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_char_ff <= pend_char_in;
      char_ff      <= char_in;
      last_ff      <= last_in;
      err_ff       <= err_in;
      if (rsp_load) begin
         rsp_has_ff  <= rsp_has_in;
         rsp_char_ff <= rsp_char_in;
         rsp_err_ff  <= rsp_err_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_has_char   = rsp_has_ff;
   assign rsp_out_char   = rsp_char_ff;
   assign rsp_error_code = rsp_err_ff;
   assign rsp_run_last   = rsp_last_ff;

endmodule
